@@ rtl/core/rdyq_pkg.sv @@
// shared types, codes and constants of the ready event queue
package rdyq_pkg;

    localparam int DEF_MAX_SOCKETS = 1024;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int SOCK_W          = 10;
    localparam int EVB_W           = 7;
    localparam int EV_W            = 6;
    localparam int DATA_W          = 64;
    localparam int MAXEV_W         = 6;
    localparam int QSIZE_W         = 7;
    localparam int SLIMIT_W        = 11;
    localparam int CFG_W           = 11;
    localparam int S_TDATA_W       = 88;
    localparam int M_TDATA_W       = 96;
    localparam logic [EVB_W-1:0] ALWAYS_ON = 7'h18;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_MODIFY = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_RAISE  = 3'd3,
        REQ_FETCH  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_ID  = 3'd1,
        ST_ALREADY = 3'd2,
        ST_NOT_REG = 3'd3,
        ST_FULL    = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_QSIZE  = 1'd0,
        CFG_SLIMIT = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_F_RING, S_F_TAB, S_F_CHK, S_F_DONE
    } state_t;

    typedef struct packed {
        logic [EVB_W-1:0]  interest;
        logic [EV_W-1:0]   pending;
        logic [DATA_W-1:0] data;
    } tab_entry_t;

    typedef struct packed {
        logic [SOCK_W-1:0] sock;
        logic [EV_W-1:0]   ev;
        logic [DATA_W-1:0] data;
    } ring_entry_t;

endpackage

@@ rtl/core/ready_event_queue_with_interest_filter_core.sv @@
// ready event queue: interest table, two ready rings and the request sequencer
//
// Requests arrive on the s_ channel, one item at a time; results leave on the
// m_ channel through an output register. Control and raise requests give one
// status item: a table read, then a write-back.
// A fetch walks the user ring then the shadow ring; each entry goes through a
// ring read, a table read, then a check and pending clear; an empty ring is
// skipped; the run stops at max_events and closes with a finished item carrying the delivered count.
// Each result of a request ends with tlast high on its final item.
// The block takes the next request once the previous one is fully issued to
// the output register. A stalled receiver holds the sequencer where it wants
// to emit; filtered entries are still consumed while the output waits.
// After reset the interest/pending table is cleared, one entry a cycle, over all
// MAX_SOCKETS entries; s_tready stays low meanwhile, config writes still land.
// Config: cfg_we with cfg_addr 0 queue_size, 1 socket_limit.
module ready_event_queue_with_interest_filter_core #(
    parameter int MAX_SOCKETS = rdyq_pkg::DEF_MAX_SOCKETS,
    parameter int QUEUE_DEPTH = rdyq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // socket_id, event_bits, user_data, queue_select, max_events
    input  logic [rdyq_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, ev_sock, event_out, data_out, delivered_count, zero pad
    output logic [rdyq_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [rdyq_pkg::CFG_W-1:0]     cfg_wdata
);
    import rdyq_pkg::*;

    localparam int SW = $clog2(MAX_SOCKETS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [2:0]         req_reg, req_next;
    logic [SOCK_W-1:0]  sock_reg, sock_next;
    logic [EVB_W-1:0]   evb_reg, evb_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic               q_reg, q_next;
    logic [MAXEV_W-1:0] maxev_reg, maxev_next;
    logic [MAXEV_W-1:0] fcnt_reg, fcnt_next;
    logic [PW-1:0]      head_reg [2];
    logic [PW-1:0]      head_next [2];
    logic [PW-1:0]      tail_reg [2];
    logic [PW-1:0]      tail_next [2];
    logic [CW-1:0]      count_reg [2];
    logic [CW-1:0]      count_next [2];
    logic [QSIZE_W-1:0] qsize_reg;
    logic [SLIMIT_W-1:0] slimit_reg;

    logic                 mv_reg, mv_next;
    logic [M_TDATA_W-1:0] md_reg, md_next;
    logic [1:0]           mu_reg, mu_next;
    logic                 ml_reg, ml_next;

    logic        tab_rd_en, tab_wr_en, clr_busy;
    logic [SW-1:0] tab_rd_addr, tab_wr_addr;
    tab_entry_t  tab_rd_data, tab_wr_data;
    logic        ring_rd_en, ring_wr_en;
    logic [PW:0] ring_rd_addr, ring_wr_addr;
    ring_entry_t ring_rd_data, ring_wr_data;

    logic          out_free, bad_id, keep;
    logic [CW-1:0] eff;
    logic [EV_W-1:0] ev;
    status_t       st;

    rdyq_sock_table #(.MAX_SOCKETS(MAX_SOCKETS), .SW(SW)) u_table (
        .aclk(aclk), .aresetn(aresetn),
        .rd_en(tab_rd_en), .rd_addr(tab_rd_addr), .rd_data(tab_rd_data),
        .wr_en(tab_wr_en), .wr_addr(tab_wr_addr), .wr_data(tab_wr_data),
        .clr_busy(clr_busy)
    );

    rdyq_ring_mem #(.AW(PW + 1)) u_ring (
        .aclk(aclk),
        .rd_en(ring_rd_en), .rd_addr(ring_rd_addr), .rd_data(ring_rd_data),
        .wr_en(ring_wr_en), .wr_addr(ring_wr_addr), .wr_data(ring_wr_data)
    );

    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    // ring size clamped to 1..QUEUE_DEPTH
    always_comb begin
        if (qsize_reg == '0) begin
            eff = CW'(1);
        end else if (32'(qsize_reg) > QUEUE_DEPTH) begin
            eff = CW'(QUEUE_DEPTH);
        end else begin
            eff = CW'(qsize_reg);
        end
    end

    assign bad_id = ({1'b0, sock_reg} >= slimit_reg) || (32'(sock_reg) >= MAX_SOCKETS);
    assign ev     = evb_reg[EV_W-1:0];
    assign keep   = ((tab_rd_data.interest[EV_W-1:0] & ring_rd_data.ev) != '0)
                    && ((tab_rd_data.pending & ring_rd_data.ev) != '0);

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        sock_next  = sock_reg;
        evb_next   = evb_reg;
        data_next  = data_reg;
        q_next     = q_reg;
        maxev_next = maxev_reg;
        fcnt_next  = fcnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        s_tready   = 1'b0;
        tab_rd_en  = 1'b0;
        tab_rd_addr = SW'(s_tdata[9:0]);
        tab_wr_en  = 1'b0;
        tab_wr_addr = SW'(sock_reg);
        tab_wr_data = tab_rd_data;
        ring_rd_en = 1'b0;
        ring_rd_addr = {q_reg, head_reg[q_reg]};
        ring_wr_en = 1'b0;
        ring_wr_addr = {q_reg, tail_reg[q_reg]};
        ring_wr_data.sock = sock_reg;
        ring_wr_data.ev   = ev;
        ring_wr_data.data = tab_rd_data.data;
        st = ST_OK;

        unique case (state_reg)
            S_CLEAR: begin
                if (!clr_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    sock_next  = s_tdata[9:0];
                    evb_next   = s_tdata[16:10];
                    data_next  = s_tdata[80:17];
                    q_next     = s_tdata[81];
                    maxev_next = s_tdata[87:82];
                    tab_rd_en  = 1'b1;
                    if (s_tuser == REQ_FETCH) begin
                        q_next     = 1'b0;
                        fcnt_next  = '0;
                        state_next = S_F_RING;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (req_reg > REQ_FETCH) begin
                        st = ST_OK;
                    end else if (bad_id) begin
                        st = ST_BAD_ID;
                    end else if (req_reg == REQ_ADD || req_reg == REQ_MODIFY) begin
                        if ((req_reg == REQ_ADD) && tab_rd_data.interest != '0) begin
                            st = ST_ALREADY;
                        end else if ((req_reg == REQ_MODIFY) && tab_rd_data.interest == '0) begin
                            st = ST_NOT_REG;
                        end else begin
                            tab_wr_en = 1'b1;
                            tab_wr_data.interest = evb_reg | ALWAYS_ON;
                            tab_wr_data.data     = data_reg;
                        end
                    end else if (req_reg == REQ_DELETE) begin
                        if (tab_rd_data.interest == '0) begin
                            st = ST_NOT_REG;
                        end else begin
                            tab_wr_en = 1'b1;
                            tab_wr_data.interest = '0;
                        end
                    end else begin
                        if (ev == '0) begin
                            st = ST_EMPTY;
                        end else if ((tab_rd_data.pending & ev) != '0) begin
                            st = ST_OK;
                        end else if (count_reg[q_reg] >= eff) begin
                            st = ST_FULL;
                        end else begin
                            tab_wr_en = 1'b1;
                            tab_wr_data.pending = tab_rd_data.pending | ev;
                            ring_wr_en = 1'b1;
                            tail_next[q_reg] = (32'(tail_reg[q_reg]) + 1 >= 32'(eff))
                                               ? '0 : tail_reg[q_reg] + 1'b1;
                            count_next[q_reg] = count_reg[q_reg] + 1'b1;
                        end
                    end
                    mv_next    = 1'b1;
                    mu_next    = KIND_STATUS;
                    ml_next    = 1'b1;
                    md_next    = {{(M_TDATA_W - 3){1'b0}}, st};
                    state_next = S_IDLE;
                end
            end
            S_F_RING: begin
                if (fcnt_reg >= maxev_reg) begin
                    state_next = S_F_DONE;
                end else if (count_reg[q_reg] == '0) begin
                    if (!q_reg) begin
                        q_next = 1'b1;
                    end else begin
                        state_next = S_F_DONE;
                    end
                end else begin
                    ring_rd_en = 1'b1;
                    state_next = S_F_TAB;
                end
            end
            S_F_TAB: begin
                tab_rd_en   = 1'b1;
                tab_rd_addr = SW'(ring_rd_data.sock);
                state_next  = S_F_CHK;
            end
            S_F_CHK: begin
                if (!keep || out_free) begin
                    tab_wr_en   = 1'b1;
                    tab_wr_addr = SW'(ring_rd_data.sock);
                    tab_wr_data.pending = tab_rd_data.pending & ~ring_rd_data.ev;
                    head_next[q_reg] = (32'(head_reg[q_reg]) + 1 >= 32'(eff))
                                       ? '0 : head_reg[q_reg] + 1'b1;
                    count_next[q_reg] = count_reg[q_reg] - 1'b1;
                    if (keep) begin
                        mv_next   = 1'b1;
                        mu_next   = KIND_EVENT;
                        ml_next   = 1'b0;
                        md_next   = {7'b0, 6'b0, ring_rd_data.data, ring_rd_data.ev,
                                     ring_rd_data.sock, ST_OK};
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    state_next = S_F_RING;
                end
            end
            S_F_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mu_next    = KIND_DONE;
                    ml_next    = 1'b1;
                    md_next    = {7'b0, fcnt_reg, 64'b0, 6'b0, 10'b0, ST_OK};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            mv_reg     <= 1'b0;
            head_reg   <= '{default: '0};
            tail_reg   <= '{default: '0};
            count_reg  <= '{default: '0};
            qsize_reg  <= QSIZE_W'(64);
            slimit_reg <= SLIMIT_W'(1024);
            fcnt_reg   <= '0;
            maxev_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fcnt_reg  <= fcnt_next;
            maxev_reg <= maxev_next;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_QSIZE:  qsize_reg  <= cfg_wdata[QSIZE_W-1:0];
                    CFG_SLIMIT: slimit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        sock_reg <= sock_next;
        evb_reg  <= evb_next;
        data_reg <= data_next;
        q_reg    <= q_next;
        md_reg   <= md_next;
        mu_reg   <= mu_next;
        ml_reg   <= ml_next;
    end

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken during table clear");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg[0]) <= QUEUE_DEPTH) && (32'(count_reg[1]) <= QUEUE_DEPTH))
        else $error("ring count beyond depth");

    a_fetch_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_F_RING || state_reg == S_F_TAB || state_reg == S_F_CHK)
        |-> fcnt_reg <= maxev_reg)
        else $error("fetch delivered too many items");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DONE) |-> m_tlast)
        else $error("finished item without last");

endmodule

@@ rtl/core/rdyq_sock_table.sv @@
// per-socket table memory with a clearing pass after reset
module rdyq_sock_table #(
    parameter int MAX_SOCKETS = rdyq_pkg::DEF_MAX_SOCKETS,
    parameter int SW = $clog2(MAX_SOCKETS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [SW-1:0]        rd_addr,
    output rdyq_pkg::tab_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [SW-1:0]        wr_addr,
    input  rdyq_pkg::tab_entry_t wr_data,
    output logic                 clr_busy
);
    import rdyq_pkg::*;

    tab_entry_t mem [MAX_SOCKETS];
    logic [SW:0] clr_cnt_reg;
    logic        clr_busy_reg;

    assign clr_busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == MAX_SOCKETS - 1) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg[SW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/rdyq_ring_mem.sv @@
// storage of both ready rings, one entry per socket event
module rdyq_ring_mem #(
    parameter int AW = 7
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output rdyq_pkg::ring_entry_t rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  rdyq_pkg::ring_entry_t wr_data
);
    import rdyq_pkg::*;

    ring_entry_t mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
